>>> src/assert_macros.svh
// Assertion helper macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define AST_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted (active low).
`define AST_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> src/ffha_pkg.sv
// ----------------------------------------------------------------------------
// ffha_pkg
// Constants, header layout and state codes of the first-fit heap allocator.
// ----------------------------------------------------------------------------
package ffha_pkg;

    localparam int HEAP_BYTES      = 8192;
    localparam int GRANULE_BYTES   = 16;
    localparam int HEADER_GRANULES = 2;
    localparam int NGRAN           = HEAP_BYTES / GRANULE_BYTES;

    localparam int GW    = $clog2(NGRAN);          // granule index width
    localparam int GSH   = $clog2(GRANULE_BYTES);  // byte-to-granule shift
    localparam int SW    = GW + 1;                 // block size width
    localparam int EW    = SW + 2;                 // widened index math
    localparam int OFFW  = 13;                     // offset field width
    localparam int REQW  = 14;                     // request field width
    localparam int NEEDW = REQW - GSH + 1;         // rounded request width

    typedef struct packed {
        logic [SW-1:0] size;
        logic          alloc;
        logic          palloc;
        logic [GW-1:0] prev;
        logic          prev_ok;
        logic [GW-1:0] next;
        logic          next_ok;
    } t_hdr;

    typedef enum logic [2:0] {
        M_SETNEXT,
        M_SETPREV,
        M_TAKE,
        M_PALLOC1,
        M_PALLOC0,
        M_RELEASE,
        M_GROW,
        M_PUSH
    } t_mod;

    typedef enum logic [4:0] {
        S_INIT,
        S_IDLE,
        S_RMW_RD,
        S_RMW_WR,
        S_WALK,
        S_FIT,
        S_SP_LINKP,
        S_SP_LINKN,
        S_SP_FOOT,
        S_UL_P,
        S_UL_N,
        S_A_PAL,
        S_A_TAKE,
        S_F_NEXT,
        S_F_NCHK,
        S_F_GROW,
        S_F_PREV,
        S_F_FOOT,
        S_F_PUSH,
        S_F_HEADP,
        S_F_HSET,
        S_F_TAIL,
        S_OUT
    } t_state;

endpackage

>>> src/first_fit_heap_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// Explicit free list heap manager with boundary tags over a fixed region.
// ----------------------------------------------------------------------------
//  channel   | handshake          | payload
//  ----------+--------------------+---------------------------------------------
//  request   | i_valid / o_stall  | i_kind, i_request_bytes, i_release_offset
//  result    | o_valid / i_stall  | o_alloc_offset, o_alloc_failed
//
//  One request at a time; o_stall is high whenever the sequencer is busy.
//  Allocate: one header read per free-list block visited, then the
//  split or unlink steps. Release: a chain of read-modify-write steps
//  (read state, then write state) on the header memory; a null release
//  goes straight to the result.
//  Reset (synchronous, low) is followed by a clearing pass over all NGRAN
//  (512) headers that zeroes every header and writes the whole-heap header at
//  granule zero. A result waits in the output register while the
//  next request is taken; a finished request holds until that register frees.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator
    import ffha_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  logic            i_kind,
    input  logic [REQW-1:0] i_request_bytes,
    input  logic [OFFW-1:0] i_release_offset,
    output logic            o_valid,
    input  logic            i_stall,
    output logic [OFFW-1:0] o_alloc_offset,
    output logic            o_alloc_failed
);

    // header memory (one entry per granule) and free-block footers
    t_hdr          r_hmem [NGRAN];
    logic [SW-1:0] r_fmem [NGRAN];
    t_hdr          r_rd;
    logic [SW-1:0] r_frd;

    t_state r_state, n_state, r_ret, n_ret;
    logic [GW-1:0]    r_cur, n_cur, r_n, n_n, r_addr, n_addr, r_lnk, n_lnk;
    logic [GW-1:0]    r_head, n_head, r_steps, n_steps;
    logic             r_head_ok, n_head_ok, r_lok, n_lok, r_kind, n_kind;
    logic [NEEDW-1:0] r_need, n_need;
    logic [SW-1:0]    r_szn, n_szn, r_val, n_val;
    t_hdr             r_h, n_h, r_u, n_u;
    t_mod             r_mod, n_mod;
    logic [OFFW-1:0]  r_res_off, n_res_off, r_oofs, n_oofs;
    logic             r_res_fail, n_res_fail, r_ofail, n_ofail;
    logic             r_ovalid, n_ovalid;

    // memory port controls
    logic          w_hwe, w_hre, w_fwe, w_fre;
    logic [GW-1:0] w_hwa, w_hra, w_fwa, w_fra;
    t_hdr          w_hwd, w_mod;
    logic [SW-1:0] w_fwd;

    // shared conditions
    logic             w_acc;
    logic [REQW:0]    w_req_sum;
    logic [NEEDW-1:0] w_need;
    logic [GW-1:0]    w_gi, w_fcur;
    logic             w_free_ok;
    logic             w_fit, w_walk_end;
    logic [EW-1:0]    w_nb, w_np, w_last, w_pbase;
    logic             w_split, w_np_in, w_last_in, w_pfit, w_alias;
    logic [GW:0]      w_gpl;
    logic [GW+GSH:0]  w_gofs;

    assign w_acc     = i_valid && !o_stall;
    assign w_req_sum = {1'b0, i_request_bytes} + (REQW+1)'(GRANULE_BYTES - 1);
    assign w_need    = w_req_sum[REQW:GSH];
    assign w_gi      = i_release_offset[OFFW-1:GSH];
    assign w_fcur    = w_gi - GW'(HEADER_GRANULES);
    assign w_free_ok = (i_release_offset != '0) && (w_gi >= GW'(HEADER_GRANULES));

    assign w_fit      = ({1'b0, r_rd.size} >= SW'(0) + r_need);
    assign w_walk_end = !r_rd.next_ok || (r_steps == GW'(NGRAN - 1));

    assign w_nb      = EW'(r_cur) + EW'(HEADER_GRANULES) + EW'(r_need);
    assign w_split   = (EW'(r_need) + EW'(HEADER_GRANULES + 1) <= EW'(r_h.size))
                       && (w_nb < EW'(NGRAN));
    assign w_np      = EW'(r_cur) + EW'(HEADER_GRANULES) + EW'(r_h.size);
    assign w_np_in   = w_np < EW'(NGRAN);
    assign w_last    = EW'(r_cur) + EW'(r_h.size) + EW'(HEADER_GRANULES - 1);
    assign w_last_in = w_last < EW'(NGRAN);
    assign w_pfit    = EW'(r_frd) + EW'(HEADER_GRANULES) <= EW'(r_cur);
    assign w_pbase   = EW'(r_cur) - EW'(r_frd) - EW'(HEADER_GRANULES);
    // prev link of the split block points at the new block itself
    assign w_alias   = r_h.prev_ok && (r_h.prev == r_n);

    assign w_gpl  = (GW+1)'(r_cur) + (GW+1)'(HEADER_GRANULES);
    assign w_gofs = {w_gpl, {GSH{1'b0}}};

    // modify step of a read-modify-write on the header memory
    always_comb begin
        w_mod = r_rd;
        case (r_mod)
            M_SETNEXT: begin
                w_mod.next    = r_lnk;
                w_mod.next_ok = r_lok;
            end
            M_SETPREV: begin
                w_mod.prev    = r_lnk;
                w_mod.prev_ok = r_lok;
            end
            M_TAKE: begin
                w_mod.size  = r_val;
                w_mod.alloc = 1'b1;
            end
            M_PALLOC1: w_mod.palloc = 1'b1;
            M_PALLOC0: w_mod.palloc = 1'b0;
            M_RELEASE: w_mod.alloc  = 1'b0;
            M_GROW:    w_mod.size   = r_rd.size + r_val;
            M_PUSH: begin
                w_mod.next    = r_head;
                w_mod.next_ok = r_head_ok;
                w_mod.prev    = '0;
                w_mod.prev_ok = 1'b0;
            end
            default: w_mod = r_rd;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_INIT: n_state = (r_steps == GW'(NGRAN - 1)) ? S_IDLE : S_INIT;
            S_IDLE: begin
                if (w_acc) begin
                    if (!i_kind) begin
                        n_state = (i_request_bytes != '0 && r_head_ok) ? S_WALK : S_OUT;
                    end else begin
                        n_state = w_free_ok ? S_RMW_RD : S_OUT;
                    end
                end
            end
            S_RMW_RD: n_state = S_RMW_WR;
            S_RMW_WR: n_state = r_ret;
            S_WALK: begin
                if (w_fit) begin
                    n_state = S_FIT;
                end else if (w_walk_end) begin
                    n_state = S_OUT;
                end
            end
            S_FIT:      n_state = w_split ? S_SP_LINKP : S_UL_P;
            S_SP_LINKP: n_state = r_h.prev_ok ? S_RMW_RD : S_SP_LINKN;
            S_SP_LINKN: n_state = (w_alias || r_h.next_ok) ? S_RMW_RD : S_SP_FOOT;
            S_SP_FOOT:  n_state = S_RMW_RD;
            S_UL_P:     n_state = r_u.prev_ok ? S_RMW_RD : S_UL_N;
            S_UL_N: begin
                if (r_u.next_ok) begin
                    n_state = S_RMW_RD;
                end else begin
                    n_state = r_kind ? S_F_GROW : S_A_PAL;
                end
            end
            S_A_PAL:  n_state = w_np_in ? S_RMW_RD : S_A_TAKE;
            S_A_TAKE: n_state = S_RMW_RD;
            S_F_NEXT: n_state = w_np_in ? S_F_NCHK : S_F_PREV;
            S_F_NCHK: n_state = r_rd.alloc ? S_F_PREV : S_UL_P;
            S_F_GROW: n_state = S_RMW_RD;
            S_F_PREV: n_state = (!r_h.palloc && r_cur != '0) ? S_F_FOOT : S_F_PUSH;
            S_F_FOOT: n_state = w_pfit ? S_RMW_RD : S_F_PUSH;
            S_F_PUSH: n_state = S_RMW_RD;
            S_F_HEADP: n_state = r_head_ok ? S_RMW_RD : S_F_HSET;
            S_F_HSET:  n_state = S_F_TAIL;
            S_F_TAIL:  n_state = w_np_in ? S_RMW_RD : S_OUT;
            S_OUT:     n_state = (!r_ovalid || !i_stall) ? S_IDLE : S_OUT;
            default:   n_state = S_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb begin
        n_ret = r_ret;  n_cur = r_cur;  n_n = r_n;  n_addr = r_addr;
        n_lnk = r_lnk;  n_lok = r_lok;  n_head = r_head;  n_head_ok = r_head_ok;
        n_steps = r_steps;  n_kind = r_kind;  n_need = r_need;  n_szn = r_szn;
        n_val = r_val;  n_h = r_h;  n_u = r_u;  n_mod = r_mod;
        n_res_off = r_res_off;  n_res_fail = r_res_fail;
        n_oofs = r_oofs;  n_ofail = r_ofail;
        n_ovalid = r_ovalid && i_stall;
        w_hwe = 1'b0;  w_hwa = r_addr;  w_hwd = w_mod;
        w_hre = 1'b0;  w_hra = r_addr;
        w_fwe = 1'b0;  w_fwa = w_last[GW-1:0];  w_fwd = r_h.size;
        w_fre = 1'b0;  w_fra = r_cur - GW'(1);
        unique case (r_state)
            S_INIT: begin
                // clearing pass: one header per cycle, whole-heap block at zero
                w_hwe   = 1'b1;
                w_hwa   = r_steps;
                w_hwd   = '0;
                n_steps = r_steps + GW'(1);
                if (r_steps == '0) begin
                    w_hwd = '{size: SW'(NGRAN - HEADER_GRANULES), alloc: 1'b0,
                              palloc: 1'b1, prev: '0, prev_ok: 1'b0,
                              next: '0, next_ok: 1'b0};
                end
            end
            S_IDLE: begin
                if (w_acc) begin
                    n_kind     = i_kind;
                    n_need     = w_need;
                    n_res_off  = '0;
                    n_res_fail = !i_kind;
                    if (!i_kind) begin
                        n_cur   = r_head;
                        n_steps = '0;
                        w_hre   = 1'b1;
                        w_hra   = r_head;
                    end else begin
                        n_res_fail = 1'b0;
                        n_cur  = w_fcur;
                        n_addr = w_fcur;
                        n_mod  = M_RELEASE;
                        n_ret  = S_F_NEXT;
                    end
                end
            end
            S_RMW_RD: begin
                w_hre = 1'b1;
                w_hra = r_addr;
            end
            S_RMW_WR: begin
                w_hwe = 1'b1;
                if (r_kind && r_addr == r_cur) begin
                    n_h = w_mod;
                end
            end
            S_WALK: begin
                if (w_fit) begin
                    n_h        = r_rd;
                    n_res_off  = w_gofs[OFFW-1:0];
                    n_res_fail = 1'b0;
                end else if (!w_walk_end) begin
                    n_cur   = r_rd.next;
                    n_steps = r_steps + GW'(1);
                    w_hre   = 1'b1;
                    w_hra   = r_rd.next;
                end
            end
            S_FIT: begin
                if (w_split) begin
                    n_n   = w_nb[GW-1:0];
                    n_szn = r_h.size - SW'(r_need) - SW'(HEADER_GRANULES);
                    w_hwe = 1'b1;
                    w_hwa = w_nb[GW-1:0];
                    w_hwd = '{size: r_h.size - SW'(r_need) - SW'(HEADER_GRANULES),
                              alloc: 1'b0, palloc: 1'b1,
                              prev: r_h.prev, prev_ok: r_h.prev_ok,
                              next: r_h.next, next_ok: r_h.next_ok};
                end else begin
                    n_u = r_h;
                end
            end
            S_SP_LINKP: begin
                if (r_h.prev_ok) begin
                    n_addr = r_h.prev;  n_mod = M_SETNEXT;
                    n_lnk  = r_n;       n_lok = 1'b1;  n_ret = S_SP_LINKN;
                end else begin
                    n_head = r_n;  n_head_ok = 1'b1;
                end
            end
            S_SP_LINKN: begin
                n_addr = w_alias ? r_n : r_h.next;
                n_mod  = M_SETPREV;  n_lnk = r_n;  n_lok = 1'b1;  n_ret = S_SP_FOOT;
            end
            S_SP_FOOT: begin
                w_fwe  = w_last_in;
                w_fwd  = r_szn;
                n_addr = r_cur;  n_mod = M_TAKE;  n_val = SW'(r_need);  n_ret = S_OUT;
            end
            S_UL_P: begin
                if (r_u.prev_ok) begin
                    n_addr = r_u.prev;  n_mod = M_SETNEXT;
                    n_lnk  = r_u.next;  n_lok = r_u.next_ok;  n_ret = S_UL_N;
                end else begin
                    n_head = r_u.next;  n_head_ok = r_u.next_ok;
                end
            end
            S_UL_N: begin
                n_addr = r_u.next;  n_mod = M_SETPREV;
                n_lnk  = r_u.prev;  n_lok = r_u.prev_ok;
                n_ret  = r_kind ? S_F_GROW : S_A_PAL;
            end
            S_A_PAL: begin
                n_addr = w_np[GW-1:0];  n_mod = M_PALLOC1;  n_ret = S_A_TAKE;
            end
            S_A_TAKE: begin
                n_addr = r_cur;  n_mod = M_TAKE;  n_val = r_h.size;  n_ret = S_OUT;
            end
            S_F_NEXT: begin
                w_hre = w_np_in;
                w_hra = w_np[GW-1:0];
            end
            S_F_NCHK: begin
                n_u = r_rd;
            end
            S_F_GROW: begin
                n_addr = r_cur;  n_mod = M_GROW;
                n_val  = r_u.size + SW'(HEADER_GRANULES);  n_ret = S_F_PREV;
            end
            S_F_PREV: begin
                w_fre = !r_h.palloc && r_cur != '0;
            end
            S_F_FOOT: begin
                if (w_pfit) begin
                    n_cur  = w_pbase[GW-1:0];
                    n_addr = w_pbase[GW-1:0];
                    n_mod  = M_GROW;
                    n_val  = r_h.size + SW'(HEADER_GRANULES);
                    n_ret  = S_F_TAIL;
                end
            end
            S_F_PUSH: begin
                n_addr = r_cur;  n_mod = M_PUSH;  n_ret = S_F_HEADP;
            end
            S_F_HEADP: begin
                n_addr = r_head;  n_mod = M_SETPREV;
                n_lnk  = r_cur;   n_lok = 1'b1;  n_ret = S_F_HSET;
            end
            S_F_HSET: begin
                n_head = r_cur;  n_head_ok = 1'b1;
            end
            S_F_TAIL: begin
                w_fwe  = w_last_in;
                n_addr = w_np[GW-1:0];  n_mod = M_PALLOC0;  n_ret = S_OUT;
            end
            S_OUT: begin
                if (!r_ovalid || !i_stall) begin
                    n_ovalid = 1'b1;
                    n_oofs   = r_res_off;
                    n_ofail  = r_res_fail;
                end
            end
            default: ;
        endcase
    end

    // memories: one write and one read per cycle each, registered read data
    always_ff @(posedge i_clk) begin
        if (w_hwe) begin
            r_hmem[w_hwa] <= w_hwd;
        end
        if (w_hre) begin
            r_rd <= r_hmem[w_hra];
        end
        if (w_fwe) begin
            r_fmem[w_fwa] <= w_fwd;
        end
        if (w_fre) begin
            r_frd <= r_fmem[w_fra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_INIT;
            r_head    <= '0;
            r_head_ok <= 1'b1;
            r_ovalid  <= 1'b0;
            r_steps   <= '0;
        end else begin
            r_state   <= n_state;
            r_head    <= n_head;
            r_head_ok <= n_head_ok;
            r_ovalid  <= n_ovalid;
            r_steps   <= n_steps;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ret      <= n_ret;
        r_cur      <= n_cur;
        r_n        <= n_n;
        r_addr     <= n_addr;
        r_lnk      <= n_lnk;
        r_lok      <= n_lok;
        r_kind     <= n_kind;
        r_need     <= n_need;
        r_szn      <= n_szn;
        r_val      <= n_val;
        r_h        <= n_h;
        r_u        <= n_u;
        r_mod      <= n_mod;
        r_res_off  <= n_res_off;
        r_res_fail <= n_res_fail;
        r_oofs     <= n_oofs;
        r_ofail    <= n_ofail;
    end

    assign o_stall        = (r_state != S_IDLE);
    assign o_valid        = r_ovalid;
    assign o_alloc_offset = r_oofs;
    assign o_alloc_failed = r_ofail;

endmodule

>>> src/ffha_chk.sv
// ----------------------------------------------------------------------------
// ffha_chk
// Port-level checks of the heap allocator, bound to its top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ffha_chk
    import ffha_pkg::*;
(
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_valid,
    input logic            o_stall,
    input logic            o_valid,
    input logic            i_stall,
    input logic [OFFW-1:0] o_alloc_offset,
    input logic            o_alloc_failed
);

    // a failed allocate never reports an offset
    `AST_IMPL(a_fail_zero, i_clk, i_rst_n, o_valid && o_alloc_failed, o_alloc_offset == '0)

    // granted offsets sit past a header and on a granule boundary
    `AST_IMPL(a_ofs_shape, i_clk, i_rst_n, o_valid && o_alloc_offset != '0,
        !o_alloc_failed && o_alloc_offset >= OFFW'(HEADER_GRANULES * GRANULE_BYTES) &&
        o_alloc_offset[GSH-1:0] == '0)

    // a stalled result holds
    `AST_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall,
        o_valid && $stable(o_alloc_offset) && $stable(o_alloc_failed))

    // an accepted request occupies the block for at least the next cycle
    `AST_NEXT(a_busy_after, i_clk, i_rst_n, i_valid && !o_stall, o_stall)

endmodule

bind first_fit_heap_allocator ffha_chk u_ffha_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_stall        (o_stall),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_alloc_offset (o_alloc_offset),
    .o_alloc_failed (o_alloc_failed)
);

>>> tb/tb_first_fit_heap_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_first_fit_heap_allocator
// Self-checking bench: a small heap model predicts each grant or release
// result from the accepted requests, and a scoreboard compares every result
// in order. Directed corner cases come first, then about 1700 random
// requests. The random part runs in three idle/stall phases and includes one
// long output hold-off.
// ----------------------------------------------------------------------------
module tb_first_fit_heap_allocator;
    import ffha_pkg::*;

    localparam int KIND_ALLOC   = 0;
    localparam int KIND_RELEASE = 1;
    localparam int N_RANDOM     = 1700;
    localparam int STALL_LIMIT  = 3000;   // cycles with no handshake at all
    localparam int HOLD_CYCLES  = 400;    // long receiver hold-off
    localparam int DRAIN_CYCLES = 60;

    // ------------------------------------------------------------------------
    // Heap model and in-order result scoreboard
    // ------------------------------------------------------------------------
    class heap_scoreboard;
        typedef struct {
            logic [OFFW-1:0] offset;
            logic            failed;
        } grant_t;

        // per-granule header fields, footers and the list head
        int unsigned blk_size[NGRAN];
        bit          blk_alloc[NGRAN];
        bit          blk_palloc[NGRAN];
        int unsigned blk_prev[NGRAN];
        int unsigned blk_next[NGRAN];
        bit          blk_prev_ok[NGRAN];
        bit          blk_next_ok[NGRAN];
        int unsigned foot_size[NGRAN];
        bit          foot_written[NGRAN];
        int unsigned head;
        bit          head_ok;

        grant_t      pending[$];
        int          live[$];      // payload offsets currently granted
        int          errors;

        function void clear();
            for (int i = 0; i < NGRAN; i++) begin
                blk_size[i] = 0; blk_alloc[i] = 0; blk_palloc[i] = 0;
                blk_prev[i] = 0; blk_next[i] = 0;
                blk_prev_ok[i] = 0; blk_next_ok[i] = 0;
                foot_size[i] = 0; foot_written[i] = 0;
            end
            blk_size[0]   = NGRAN - HEADER_GRANULES;
            blk_palloc[0] = 1;
            head    = 0;
            head_ok = 1;
            pending.delete();
            live.delete();
            errors = 0;
        endfunction

        function void link_next(int unsigned p, bit p_ok, int unsigned v, bit v_ok);
            if (!p_ok) begin
                head = v; head_ok = v_ok;
            end else if (p < NGRAN) begin
                blk_next[p] = v; blk_next_ok[p] = v_ok;
            end
        endfunction

        function void link_prev(int unsigned n, bit n_ok, int unsigned v, bit v_ok);
            if (n_ok && n < NGRAN) begin
                blk_prev[n] = v; blk_prev_ok[n] = v_ok;
            end
        endfunction

        function void unlink(int unsigned b);
            link_next(blk_prev[b], blk_prev_ok[b], blk_next[b], blk_next_ok[b]);
            link_prev(blk_next[b], blk_next_ok[b], blk_prev[b], blk_prev_ok[b]);
        endfunction

        function void put_footer(longint b);
            longint last;
            last = b + HEADER_GRANULES + longint'(blk_size[b]) - 1;
            if (last < NGRAN) begin
                foot_size[last]    = blk_size[b];
                foot_written[last] = 1;
            end
        endfunction

        // first-fit walk; split when a header plus one granule remains
        function int unsigned grant(longint req, output bit failed);
            longint need, sz, nb, np;
            int unsigned cur, n;
            bit ok;
            need   = (req + GRANULE_BYTES - 1) / GRANULE_BYTES;
            cur    = head;
            ok     = head_ok;
            failed = 1;
            if (req == 0) return 0;
            for (int steps = 0; ok && cur < NGRAN && steps < NGRAN; steps++) begin
                sz = blk_size[cur];
                if (need <= sz) begin
                    nb = longint'(cur) + HEADER_GRANULES + need;
                    if (need + HEADER_GRANULES + 1 <= sz && nb < NGRAN) begin
                        n = nb;
                        blk_size[n]    = sz - need - HEADER_GRANULES;
                        blk_alloc[n]   = 0;
                        blk_palloc[n]  = 1;
                        blk_prev[n]    = blk_prev[cur];
                        blk_prev_ok[n] = blk_prev_ok[cur];
                        blk_next[n]    = blk_next[cur];
                        blk_next_ok[n] = blk_next_ok[cur];
                        link_next(blk_prev[n], blk_prev_ok[n], n, 1);
                        link_prev(blk_next[n], blk_next_ok[n], n, 1);
                        put_footer(n);
                        blk_size[cur] = need;
                    end else begin
                        np = longint'(cur) + HEADER_GRANULES + sz;
                        unlink(cur);
                        if (np < NGRAN) blk_palloc[np] = 1;
                    end
                    blk_alloc[cur] = 1;
                    failed = 0;
                    return (cur + HEADER_GRANULES) * GRANULE_BYTES;
                end
                ok  = blk_next_ok[cur];
                cur = blk_next[cur];
            end
            return 0;
        endfunction

        // coalesce with next, then with previous through its footer
        function void release_blk(longint off);
            longint gi, cur, np, psz;
            bit merged;
            gi = off / GRANULE_BYTES;
            if (off == 0 || gi < HEADER_GRANULES || gi - HEADER_GRANULES >= NGRAN) return;
            cur = gi - HEADER_GRANULES;
            blk_alloc[cur] = 0;
            np = cur + HEADER_GRANULES + longint'(blk_size[cur]);
            if (np < NGRAN && !blk_alloc[np]) begin
                unlink(np);
                blk_size[cur] += blk_size[np] + HEADER_GRANULES;
            end
            merged = 0;
            if (!blk_palloc[cur] && cur > 0) begin
                psz = foot_size[cur - 1];
                if (psz + HEADER_GRANULES <= cur) begin
                    blk_size[cur - psz - HEADER_GRANULES] += blk_size[cur] + HEADER_GRANULES;
                    cur    = cur - psz - HEADER_GRANULES;
                    merged = 1;
                end
            end
            if (!merged) begin
                blk_next[cur]    = head;
                blk_next_ok[cur] = head_ok;
                blk_prev[cur]    = 0;
                blk_prev_ok[cur] = 0;
                link_prev(head, head_ok, cur, 1);
                head    = cur;
                head_ok = 1;
            end
            put_footer(cur);
            np = cur + HEADER_GRANULES + longint'(blk_size[cur]);
            if (np < NGRAN) blk_palloc[np] = 0;
        endfunction

        // a release must never make the block read a footer never written
        function bit release_is_safe(int off);
            int gi, cur;
            gi = off / GRANULE_BYTES;
            if (off == 0 || gi < HEADER_GRANULES) return 1;
            cur = gi - HEADER_GRANULES;
            if (cur >= NGRAN) return 1;
            return !(!blk_palloc[cur] && cur > 0 && !foot_written[cur - 1]);
        endfunction

        function void note_request(bit kind, int req, int off);
            grant_t g;
            bit f;
            int base;
            if (kind == KIND_ALLOC) begin
                g.offset = grant(req, f);
                g.failed = f;
                if (!f) live.push_back(int'(g.offset));
            end else begin
                release_blk(off);
                base = off & ~(GRANULE_BYTES - 1);
                foreach (live[i]) if (live[i] == base) begin
                    live.delete(i);
                    break;
                end
                g.offset = '0;
                g.failed = 0;
            end
            pending.push_back(g);
        endfunction

        function void check_result(logic [OFFW-1:0] offset, logic failed);
            grant_t g;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result offset=%0d failed=%0b",
                         $realtime, offset, failed);
                errors++;
                return;
            end
            g = pending.pop_front();
            if (offset !== g.offset) begin
                $display("%0t: alloc_offset mismatch: expected %0d, actual %0d",
                         $realtime, g.offset, offset);
                errors++;
            end
            if (failed !== g.failed) begin
                $display("%0t: alloc_failed mismatch: expected %0b, actual %0b",
                         $realtime, g.failed, failed);
                errors++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------------
    logic            i_clk = 0;
    logic            i_rst_n = 0;
    logic            i_valid = 0;
    logic            o_stall;
    logic            i_kind = 0;
    logic [REQW-1:0] i_request_bytes = '0;
    logic [OFFW-1:0] i_release_offset = '0;
    logic            o_valid;
    logic            i_stall = 0;
    logic [OFFW-1:0] o_alloc_offset;
    logic            o_alloc_failed;

    first_fit_heap_allocator u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_kind          (i_kind),
        .i_request_bytes (i_request_bytes),
        .i_release_offset(i_release_offset),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_alloc_offset  (o_alloc_offset),
        .o_alloc_failed  (o_alloc_failed)
    );

    heap_scoreboard sb = new();

    int tx_idle_pct = 0;      // sender gap chance per request
    int rx_idle_pct = 0;      // receiver stall chance per cycle
    int n_sent      = 0;
    bit hold_done   = 0;
    int hold_left   = 0;
    int quiet_cycles = 0;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Result side: random stall, plus one long hold-off while the sender
    // keeps offering requests so the block backs up and stalls its input.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_stall   <= 1'b1;
        end else if (!hold_done && n_sent == 1250) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            i_stall   <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(0, 99) < rx_idle_pct);
        end
    end

    // Result monitor and watchdog; samples values from before this edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall)
                sb.check_result(o_alloc_offset, o_alloc_failed);
            if ((o_valid && !i_stall) || (i_valid && !o_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------------
    // Drive one request and hold it until the block takes it.
    task automatic send_request(bit kind, int req, int off);
        if ($urandom_range(0, 99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_valid          <= 1'b1;
        i_kind           <= kind;
        i_request_bytes  <= req[REQW-1:0];
        i_release_offset <= off[OFFW-1:0];
        do @(posedge i_clk); while (o_stall);
        sb.note_request(kind, req, off);
        n_sent++;
    endtask

    task automatic send_alloc(int req);
        send_request(KIND_ALLOC, req, $urandom_range(0, 8191));
    endtask

    // release with a random request field; unsafe offsets degrade to null
    task automatic send_release(int off);
        if (!sb.release_is_safe(off)) off = 0;
        send_request(KIND_RELEASE, $urandom_range(0, 16383), off);
    endtask

    // Random request size: mostly small, some large, rare zero / oversize.
    function automatic int pick_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 3)  return 0;
        if (r < 6)  return $urandom_range(8161, 16383);
        if (r < 15) return $urandom_range(257, 4096);
        return $urandom_range(1, 256);
    endfunction

    initial begin : stimulus
        int a, b, c, d, r, off;
        sb.clear();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // ---- directed corner cases ----
        send_alloc(0);               // size zero fails
        send_alloc(8192);            // larger than the heap
        send_alloc(16383);           // all request bits set
        send_release(0);             // null release
        send_release(16);            // maps below granule zero
        send_alloc(1);   a = sb.live[$];
        send_alloc(16);  b = sb.live[$];
        send_alloc(17);  c = sb.live[$];
        send_alloc(48);  d = sb.live[$];
        send_release(b);             // plain push at list head
        send_release(a + 7);         // low offset bits dropped, merges with next
        send_release(d);             // merges with the free tail
        send_release(c);             // joins both neighbors
        send_alloc(8160);            // whole heap, no split, list empties
        send_alloc(1);               // empty list
        send_release(sb.live[$]);
        send_alloc(8128);            // remainder too small to split
        send_release(sb.live[$]);
        send_alloc(8112);            // remainder exactly header plus a granule
        send_alloc(16);
        send_release(sb.live[0]);
        send_release(sb.live[0]);

        // ---- random part in three idle phases ----
        for (int i = 0; i < N_RANDOM; i++) begin
            if (i == 0)                 begin tx_idle_pct = 27; rx_idle_pct = 65; end
            if (i == N_RANDOM / 3)      begin tx_idle_pct = 65; rx_idle_pct = 27; end
            if (i == 2 * N_RANDOM / 3)  begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
            r = $urandom_range(0, 99);
            if (r < 2) begin
                send_release($urandom_range(0, 8191));          // arbitrary offset
            end else if (r < 4) begin
                send_release(0);
            end else if (r < 50 && sb.live.size() > 0) begin
                off = sb.live[$urandom_range(0, sb.live.size() - 1)];
                if ($urandom_range(0, 4) == 0) off += $urandom_range(1, GRANULE_BYTES - 1);
                send_release(off);
            end else begin
                send_alloc(pick_size());
            end
        end
        i_valid <= 1'b0;

        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
